// ===== src/sorted_turn_order_queue_top_defines.svh =====
// Assertion macros for the sorted turn-order queue.
`ifndef SORTED_TURN_ORDER_QUEUE_TOP_DEFINES_SVH
`define SORTED_TURN_ORDER_QUEUE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SOTQ_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("sotq check failed");
`define SOTQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sotq check failed");
`else
`define SOTQ_ASSERT_NOW(label, clk, rst, cond, expr)
`define SOTQ_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== src/sotq_pkg.sv =====
// Types, codes and command bundles shared by the turn-order queue modules.
`timescale 1ns / 1ps
package sotq_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam logic [2:0] ACT_ADD      = 3'd0;
   localparam logic [2:0] ACT_REMOVE   = 3'd1;
   localparam logic [2:0] ACT_SET      = 3'd2;
   localparam logic [2:0] ACT_DELTA    = 3'd3;
   localparam logic [2:0] ACT_END_TURN = 3'd4;
   localparam logic [2:0] ACT_SELECT   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_NOCUR    = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         entry_id;
      logic [15:0]        key_value;
      logic signed [15:0] key_delta;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        current_valid;
      logic [7:0]  current_id;
      logic [15:0] elapsed_value;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       status_set;
      logic [1:0] status_code;
      logic       append;
      logic       scan_start;
      logic       scan_next;
      logic       write_value;
      logic       write_delta;
      logic       remove;
      logic       swap_up;
      logic       swap_down;
      logic       select;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       found;
      logic       scan_end;
      logic       full;
      logic       empty;
      logic       can_up;
      logic       can_down;
      logic       cur_flag;
      logic       out_busy;
   } dp_status_type;

endpackage

// ===== src/sorted_turn_order_queue_top.sv =====
// From the accepting edge to rsp_valid a beat may pass a decode, a scan of one
// entry per cycle, a modify, one entry move per cycle while re-sorting, a select
// and a finish; the finish waits while an earlier result is still held.
// Throughput: one beat at a time; the next beat is taken the cycle after the
// result is registered, while that result may still wait for rsp_ready.
// Reset clears the count, the current mark and the elapsed amount at once; the
// entry row itself is not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`include "sorted_turn_order_queue_top_defines.svh"
module sorted_turn_order_queue_top #(
   parameter int MAX_ENTRIES = sotq_pkg::MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sotq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sotq_pkg::rsp_type rsp_data
);
   import sotq_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sotq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   sotq_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   `SOTQ_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready, !req_ready)
   `SOTQ_ASSERT_NOW(a_no_id_without_current, clock, reset,
      rsp_valid && !rsp_data.current_valid, rsp_data.current_id == 8'h00)
   `SOTQ_ASSERT_NOW(a_full_means_max, clock, reset,
      rsp_valid && rsp_data.status == ST_FULL, rsp_data.entry_count == 5'(MAX_ENTRIES))

endmodule

// ===== src/sotq_ctrl.sv =====
// Sequencer for the turn-order queue: decodes each beat and steps the datapath.
`timescale 1ns / 1ps
module sotq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sotq_pkg::dp_status_type dp_status,
   output sotq_pkg::dp_cmd_type    dp_cmd
);
   import sotq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_MODIFY, S_RESORT, S_SELECT, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Decide next state and datapath commands
   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority case (dp_status.action)
               ACT_ADD: begin
                  if (dp_status.full) begin
                     dp_cmd.status_set  = 1'b1;
                     dp_cmd.status_code = ST_FULL;
                     state_in           = S_FINISH;
                  end else begin
                     dp_cmd.append = 1'b1;
                     state_in      = S_RESORT;
                  end
               end
               ACT_REMOVE, ACT_SET, ACT_DELTA: begin
                  dp_cmd.scan_start = 1'b1;
                  state_in          = S_SCAN;
               end
               ACT_END_TURN: begin
                  if (!dp_status.cur_flag) begin
                     dp_cmd.status_set  = 1'b1;
                     dp_cmd.status_code = ST_NOCUR;
                     state_in           = S_FINISH;
                  end else begin
                     dp_cmd.scan_start = 1'b1;
                     state_in          = S_SCAN;
                  end
               end
               ACT_SELECT: state_in = S_SELECT;
               default:    state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            if (dp_status.scan_end) begin
               dp_cmd.status_set  = 1'b1;
               dp_cmd.status_code = ST_NOTFOUND;
               state_in           = S_FINISH;
            end else if (dp_status.found) begin
               state_in = S_MODIFY;
            end else begin
               dp_cmd.scan_next = 1'b1;
            end
         end
         S_MODIFY: begin
            priority case (dp_status.action)
               ACT_REMOVE: begin
                  dp_cmd.remove = 1'b1;
                  state_in      = S_FINISH;
               end
               ACT_DELTA: begin
                  dp_cmd.write_delta = 1'b1;
                  state_in           = S_RESORT;
               end
               default: begin
                  dp_cmd.write_value = 1'b1;
                  state_in           = S_RESORT;
               end
            endcase
         end
         S_RESORT: begin
            if (dp_status.can_up) begin
               dp_cmd.swap_up = 1'b1;
            end else if (dp_status.can_down) begin
               dp_cmd.swap_down = 1'b1;
            end else if (dp_status.action == ACT_END_TURN) begin
               state_in = S_SELECT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SELECT: begin
            if (dp_status.empty) begin
               dp_cmd.status_set  = 1'b1;
               dp_cmd.status_code = ST_NOCUR;
            end else begin
               dp_cmd.select = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!dp_status.out_busy) begin
               dp_cmd.publish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sotq_dp.sv =====
// Datapath for the turn-order queue: entry row, scan pointer and result register.
`timescale 1ns / 1ps
module sotq_dp #(
   parameter int MAX_ENTRIES = sotq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sotq_pkg::req_type       req_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output sotq_pkg::rsp_type       rsp_data,
   input  sotq_pkg::dp_cmd_type    dp_cmd,
   output sotq_pkg::dp_status_type dp_status
);
   import sotq_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [7:0]         ids_ff  [MAX_ENTRIES];
   logic [15:0]        vals_ff [MAX_ENTRIES];
   logic [2:0]         action_ff;
   logic [7:0]         id_ff;
   logic [7:0]         target_ff;
   logic [15:0]        val_ff;
   logic signed [15:0] delta_ff;
   logic [CW-1:0]      ptr_ff;
   logic [CW-1:0]      occ_ff;
   logic [7:0]         cur_id_ff;
   logic               cur_flag_ff;
   logic [15:0]        elapsed_ff;
   logic [1:0]         status_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [IW-1:0]      ptr_idx;
   logic [IW-1:0]      occ_idx;
   logic [IW-1:0]      lo_idx;
   logic [CW-1:0]      ptr_next;
   logic [15:0]        cur_val;
   logic signed [17:0] delta_sum;
   logic [15:0]        sat_val;
   logic [MAX_ENTRIES-1:0] gt_vec;
   logic [CW+4:0]      occ_ext;

   assign ptr_idx  = ptr_ff[IW-1:0];
   assign occ_idx  = occ_ff[IW-1:0];
   assign ptr_next = ptr_ff + 1'b1;
   assign lo_idx   = dp_cmd.swap_up ? (ptr_idx - 1'b1) : ptr_idx;
   assign cur_val  = vals_ff[ptr_idx];

   // Saturate value plus signed delta to the unsigned 16-bit range
   assign delta_sum = $signed({2'b00, cur_val}) + 18'(delta_ff);
   always_comb begin
      if (delta_sum < 0) begin
         sat_val = '0;
      end else if (delta_sum > 18'sd65535) begin
         sat_val = 16'hFFFF;
      end else begin
         sat_val = delta_sum[15:0];
      end
   end

   // Flag each neighbour pair that is out of order
   always_comb begin
      gt_vec[0] = 1'b0;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         gt_vec[i] = vals_ff[i-1] > vals_ff[i];
      end
   end

   assign dp_status.action   = action_ff;
   assign dp_status.scan_end = ptr_ff >= occ_ff;
   assign dp_status.found    = ids_ff[ptr_idx] == target_ff;
   assign dp_status.full     = occ_ff == CW'(MAX_ENTRIES);
   assign dp_status.empty    = occ_ff == '0;
   assign dp_status.can_up   = (ptr_ff != '0) && gt_vec[ptr_idx];
   assign dp_status.can_down = (ptr_next < occ_ff) && gt_vec[ptr_next[IW-1:0]];
   assign dp_status.cur_flag = cur_flag_ff;
   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;

   // Update the entry row
   always_ff @(posedge clock) begin
      if (dp_cmd.append) begin
         ids_ff[occ_idx]  <= id_ff;
         vals_ff[occ_idx] <= val_ff;
      end
      if (dp_cmd.write_value) begin
         vals_ff[ptr_idx] <= val_ff;
      end
      if (dp_cmd.write_delta) begin
         vals_ff[ptr_idx] <= sat_val;
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if ((dp_cmd.swap_up || dp_cmd.swap_down) && IW'(i) == lo_idx) begin
            ids_ff[i]  <= ids_ff[(i + 1) % MAX_ENTRIES];
            vals_ff[i] <= vals_ff[(i + 1) % MAX_ENTRIES];
         end
         if ((dp_cmd.swap_up || dp_cmd.swap_down) && IW'(i) == lo_idx + 1'b1) begin
            ids_ff[i]  <= ids_ff[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
            vals_ff[i] <= vals_ff[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
         end
         if (dp_cmd.remove && CW'(i) >= ptr_ff && i < MAX_ENTRIES - 1) begin
            ids_ff[i]  <= ids_ff[(i + 1) % MAX_ENTRIES];
            vals_ff[i] <= vals_ff[(i + 1) % MAX_ENTRIES];
         end
         if (dp_cmd.select) begin
            vals_ff[i] <= vals_ff[i] - vals_ff[0];
         end
      end
   end

   // Hold the beat, the status, the scan pointer and the result
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         action_ff <= req_data.action;
         id_ff     <= req_data.entry_id;
         val_ff    <= req_data.key_value;
         delta_ff  <= req_data.key_delta;
         status_ff <= ST_OK;
      end
      if (dp_cmd.status_set) begin
         status_ff <= dp_cmd.status_code;
      end
      if (dp_cmd.scan_start) begin
         ptr_ff    <= '0;
         target_ff <= (action_ff == ACT_END_TURN) ? cur_id_ff : id_ff;
      end
      if (dp_cmd.scan_next || dp_cmd.swap_down) begin
         ptr_ff <= ptr_next;
      end
      if (dp_cmd.swap_up) begin
         ptr_ff <= ptr_ff - 1'b1;
      end
      if (dp_cmd.append) begin
         ptr_ff <= occ_ff;
      end
      if (dp_cmd.publish) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.current_valid <= cur_flag_ff;
         rsp_ff.current_id    <= cur_flag_ff ? cur_id_ff : 8'h00;
         rsp_ff.elapsed_value <= elapsed_ff;
         rsp_ff.entry_count   <= occ_ext[4:0];
      end
   end

   assign occ_ext = {5'b00000, occ_ff};

   // Hold count, current mark, elapsed amount and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cur_id_ff    <= '0;
         cur_flag_ff  <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.append) begin
            occ_ff <= occ_ff + 1'b1;
         end
         if (dp_cmd.remove) begin
            occ_ff <= occ_ff - 1'b1;
            if (cur_flag_ff && cur_id_ff == id_ff) begin
               cur_flag_ff <= 1'b0;
            end
         end
         if (dp_cmd.select) begin
            elapsed_ff  <= vals_ff[0];
            cur_id_ff   <= ids_ff[0];
            cur_flag_ff <= 1'b1;
         end
         if (dp_cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
